FILE: design/dq_pkg.sv
`timescale 1ns / 1ps
// shared types, widths and codes for the double-ended queue
// no dependencies; compiled before every other file of the block

package dq_pkg;

   // payload widths fixed by the word format
   localparam int OP_W          = 3;
   localparam int STATUS_W      = 2;
   localparam int COUNT_W       = 5;
   localparam int NUM_W         = 64;
   localparam int TEXT_W        = 64;
   localparam int ENTRY_W       = NUM_W + TEXT_W;
   localparam int DEPTH_DEFAULT = 16;

   // operation codes
   localparam logic [OP_W-1:0] OP_NONE       = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd4;
   localparam logic [OP_W-1:0] OP_CLEAR      = 3'd5;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   // sequencer states
   typedef enum logic [1:0] {
      SQ_IDLE,
      SQ_READ,
      SQ_LOAD
   } dq_state_type;

   // commands from the sequencer to the ring
   typedef struct packed {
      logic            exec;
      logic            fetch;
      logic [OP_W-1:0] op;
   } dq_cmd_type;

   // status of the ring after the last operation
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
      logic                empty;
   } dq_view_type;

endpackage

FILE: design/dq_req_if.sv
`timescale 1ns / 1ps
// request channel: valid/ready handshake carrying one operation word
// depends on dq_pkg

interface dq_req_if;
   import dq_pkg::*;

   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [NUM_W-1:0]  item_number;
   logic [TEXT_W-1:0] item_text;

   modport source (output valid, output op, output item_number, output item_text,
                   input ready);
   modport sink   (input valid, input op, input item_number, input item_text,
                   output ready);
endinterface

FILE: design/dq_rsp_if.sv
`timescale 1ns / 1ps
// response channel: valid/ready handshake carrying one result word
// depends on dq_pkg

interface dq_rsp_if;
   import dq_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0]  count;
   logic [NUM_W-1:0]    front_number;
   logic [TEXT_W-1:0]   front_text;
   logic [NUM_W-1:0]    back_number;
   logic [TEXT_W-1:0]   back_text;

   modport source (output valid, output status, output count,
                   output front_number, output front_text,
                   output back_number, output back_text,
                   input ready);
   modport sink   (input valid, input status, input count,
                   input front_number, input front_text,
                   input back_number, input back_text,
                   output ready);
endinterface

FILE: design/double_ended_queue.sv
`timescale 1ns / 1ps
// Bounded double-ended queue of DEPTH entries (64-bit number plus 64-bit text
// tag) held in a ring buffer memory. Each request word is handled in order:
// the front index and count are updated and a pushed entry is written, the
// front and back entries are read from the memory's two read ports, and the
// response register is loaded when the response side is free. The registered
// memory read and the read-after-write ordering set this order. A new request
// is taken while the previous response still waits in the output register.
// The response carries status, count and the front and back entries after the
// operation, zeros when the queue is empty. No clearing pass follows reset.
// depends on dq_pkg, dq_req_if, dq_rsp_if and dq_ring

module double_ended_queue #(
   parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   dq_req_if.sink    req_ch,
   dq_rsp_if.source  rsp_ch
);
   import dq_pkg::*;

   dq_state_type        state_ff, state_in;
   dq_cmd_type          cmd;
   dq_view_type         view;
   logic [ENTRY_W-1:0]  front_rd;
   logic [ENTRY_W-1:0]  back_rd;
   logic                load;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic [ENTRY_W-1:0]  rsp_front_ff;
   logic [ENTRY_W-1:0]  rsp_back_ff;

   // ring core
   dq_ring #(
      .DEPTH (DEPTH)
   ) u_ring (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .item_number (req_ch.item_number),
      .item_text   (req_ch.item_text),
      .view        (view),
      .front_rd    (front_rd),
      .back_rd     (back_rd)
   );

   // sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // sequencer next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd.exec     = 1'b0;
      cmd.fetch    = 1'b0;
      cmd.op       = req_ch.op;
      req_ch.ready = 1'b0;
      load         = 1'b0;
      case (state_ff)
         SQ_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               cmd.exec = 1'b1;
               state_in = SQ_READ;
            end
         end
         SQ_READ: begin
            cmd.fetch = 1'b1;
            state_in  = SQ_LOAD;
         end
         SQ_LOAD: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               load     = 1'b1;
               state_in = SQ_IDLE;
            end
         end
         default: begin
            state_in = SQ_IDLE;
         end
      endcase
   end

   // response valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload, entries zeroed when the queue is empty
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_status_ff <= view.status;
         rsp_count_ff  <= view.count;
         rsp_front_ff  <= view.empty ? '0 : front_rd;
         rsp_back_ff   <= view.empty ? '0 : back_rd;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.count        = rsp_count_ff;
   assign rsp_ch.front_number = rsp_front_ff[ENTRY_W-1:TEXT_W];
   assign rsp_ch.front_text   = rsp_front_ff[TEXT_W-1:0];
   assign rsp_ch.back_number  = rsp_back_ff[ENTRY_W-1:TEXT_W];
   assign rsp_ch.back_text    = rsp_back_ff[TEXT_W-1:0];

   // an accepted word is followed by the memory read state, then the load state
   a_accept_read: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> state_ff == SQ_READ ##1 state_ff == SQ_LOAD)
      else $error("accepted word not followed by memory read");

   // an empty queue answers with zero entries
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      load && view.empty |=> rsp_front_ff == '0 && rsp_back_ff == '0)
      else $error("empty queue reported entries");

endmodule

FILE: design/dq_ring.sv
`timescale 1ns / 1ps
// ring buffer core: front index, entry count and the entry memory
// depends on dq_pkg

module dq_ring #(
   parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  dq_pkg::dq_cmd_type          cmd,
   input  logic [dq_pkg::NUM_W-1:0]    item_number,
   input  logic [dq_pkg::TEXT_W-1:0]   item_text,
   output dq_pkg::dq_view_type         view,
   output logic [dq_pkg::ENTRY_W-1:0]  front_rd,
   output logic [dq_pkg::ENTRY_W-1:0]  back_rd
);
   import dq_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   logic [IDX_W-1:0]    front_ff, front_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [ENTRY_W-1:0]  entry_store_ff [DEPTH];
   logic [ENTRY_W-1:0]  front_rd_ff;
   logic [ENTRY_W-1:0]  back_rd_ff;

   logic                is_full;
   logic                is_empty;
   logic [IDX_W-1:0]    front_dec;
   logic [IDX_W-1:0]    front_inc;
   logic [SUM_W-1:0]    tail_sum;
   logic [SUM_W-1:0]    tail_wrap;
   logic [SUM_W-1:0]    back_sum;
   logic [SUM_W-1:0]    back_wrap;
   logic [IDX_W-1:0]    tail_slot;
   logic [IDX_W-1:0]    back_slot;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [CNT_W+COUNT_W-1:0] count_wide;

   // occupancy
   assign is_full  = (count_ff == CNT_W'(DEPTH));
   assign is_empty = (count_ff == '0);

   // neighbouring slots of the front, wrapping at the ring end
   assign front_dec = (front_ff == '0) ? IDX_W'(DEPTH - 1) : front_ff - 1'b1;
   assign front_inc = (front_ff == IDX_W'(DEPTH - 1)) ? '0 : front_ff + 1'b1;

   // slot after the back (push back) and slot of the back (read)
   assign tail_sum  = SUM_W'(front_ff) + SUM_W'(count_ff);
   assign tail_wrap = (tail_sum >= SUM_W'(DEPTH)) ? tail_sum - SUM_W'(DEPTH) : tail_sum;
   assign tail_slot = tail_wrap[IDX_W-1:0];
   assign back_sum  = tail_sum - 1'b1;
   assign back_wrap = (back_sum >= SUM_W'(DEPTH)) ? back_sum - SUM_W'(DEPTH) : back_sum;
   assign back_slot = back_wrap[IDX_W-1:0];

   // next state and memory write for one operation
   always_comb begin
      front_in  = front_ff;
      count_in  = count_ff;
      status_in = ST_OK;
      wr_en     = 1'b0;
      wr_addr   = tail_slot;
      case (cmd.op)
         OP_PUSH_FRONT: begin
            if (is_full) begin
               status_in = ST_FULL;
            end else begin
               front_in = front_dec;
               count_in = count_ff + 1'b1;
               wr_en    = 1'b1;
               wr_addr  = front_dec;
            end
         end
         OP_PUSH_BACK: begin
            if (is_full) begin
               status_in = ST_FULL;
            end else begin
               count_in = count_ff + 1'b1;
               wr_en    = 1'b1;
               wr_addr  = tail_slot;
            end
         end
         OP_POP_FRONT: begin
            if (is_empty) begin
               status_in = ST_EMPTY;
            end else begin
               front_in = front_inc;
               count_in = count_ff - 1'b1;
            end
         end
         OP_POP_BACK: begin
            if (is_empty) begin
               status_in = ST_EMPTY;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         OP_CLEAR: begin
            front_in = '0;
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   // index, count and status registers
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff  <= '0;
         count_ff  <= '0;
         status_ff <= ST_OK;
      end else if (cmd.exec) begin
         front_ff  <= front_in;
         count_ff  <= count_in;
         status_ff <= status_in;
      end
   end

   // entry memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) begin
         entry_store_ff[wr_addr] <= {item_number, item_text};
      end
      if (cmd.fetch) begin
         front_rd_ff <= entry_store_ff[front_ff];
         back_rd_ff  <= entry_store_ff[back_slot];
      end
   end

   // count truncated or extended to the word field
   assign count_wide  = (CNT_W + COUNT_W)'(count_ff);
   assign view.status = status_ff;
   assign view.count  = count_wide[COUNT_W-1:0];
   assign view.empty  = is_empty;
   assign front_rd    = front_rd_ff;
   assign back_rd     = back_rd_ff;

   // ring bounds hold
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count beyond depth");

   a_front_bound: assert property (@(posedge clock) disable iff (reset)
      front_ff <= IDX_W'(DEPTH - 1))
      else $error("front index beyond depth");

   // a pop on an empty ring leaves it empty and flags it
   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && is_empty && (cmd.op == OP_POP_FRONT || cmd.op == OP_POP_BACK)
      |=> is_empty && status_ff == ST_EMPTY)
      else $error("pop on empty ring changed state");

   // a push on a full ring is dropped
   a_push_full: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && is_full && (cmd.op == OP_PUSH_FRONT || cmd.op == OP_PUSH_BACK)
      |=> is_full && status_ff == ST_FULL && $stable(front_ff))
      else $error("push on full ring not dropped");

endmodule
